### sv/rlpl_pkg.sv
// ----------------------------------------------------------------------------
// rlpl_pkg
// shared types and codes of the route lookup core
// ----------------------------------------------------------------------------
package rlpl_pkg;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 32;
  localparam int METRIC_W = 31;
  localparam int INTF_W   = 8;
  localparam int STATUS_W = 2;
  localparam int HIT_W    = 6;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]   dst;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   gateway;
    logic [METRIC_W-1:0] metric;
    logic [INTF_W-1:0]   intf;
  } route_t;

  // search token walking down the cell row
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] addr;
    logic              have;
    route_t            best;
  } token_t;

endpackage

### sv/rlpl_if.sv
// ----------------------------------------------------------------------------
// rlpl_if
// request and response channels of the route lookup core
// ----------------------------------------------------------------------------
interface rlpl_req_if;
  logic                          valid;
  logic                          ready;
  logic [rlpl_pkg::ACTION_W-1:0] action;
  logic [rlpl_pkg::ADDR_W-1:0]   route_dst;
  logic [rlpl_pkg::ADDR_W-1:0]   route_mask;
  logic [rlpl_pkg::ADDR_W-1:0]   route_gateway;
  logic [rlpl_pkg::METRIC_W-1:0] route_metric;
  logic [rlpl_pkg::INTF_W-1:0]   route_intf;
  logic [rlpl_pkg::ADDR_W-1:0]   lookup_addr;

  modport source (
    output valid, action, route_dst, route_mask, route_gateway, route_metric,
           route_intf, lookup_addr,
    input  ready
  );
  modport sink (
    input  valid, action, route_dst, route_mask, route_gateway, route_metric,
           route_intf, lookup_addr,
    output ready
  );
endinterface

interface rlpl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rlpl_pkg::STATUS_W-1:0] status;
  logic [rlpl_pkg::HIT_W-1:0]    hit_index;
  logic [rlpl_pkg::ADDR_W-1:0]   hit_dst;
  logic [rlpl_pkg::ADDR_W-1:0]   hit_mask;
  logic [rlpl_pkg::ADDR_W-1:0]   hit_gateway;
  logic [rlpl_pkg::METRIC_W-1:0] hit_metric;
  logic [rlpl_pkg::INTF_W-1:0]   hit_intf;

  modport source (
    output valid, status, hit_index, hit_dst, hit_mask, hit_gateway, hit_metric,
           hit_intf,
    input  ready
  );
  modport sink (
    input  valid, status, hit_index, hit_dst, hit_mask, hit_gateway, hit_metric,
           hit_intf,
    output ready
  );
endinterface

### sv/rlpl_cell.sv
// ----------------------------------------------------------------------------
// rlpl_cell
// one route slot; compares the passing token and forwards the better route
// ----------------------------------------------------------------------------
module rlpl_cell #(
  parameter int CELL_ID = 0,
  parameter int IW      = 6,
  parameter int CW      = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rlpl_pkg::route_t    wr_route,
  input  logic [CW-1:0]       count,
  input  rlpl_pkg::token_t    tok_in,
  input  logic [IW-1:0]       idx_in,
  output rlpl_pkg::token_t    tok_out,
  output logic [IW-1:0]       idx_out
);

  rlpl_pkg::route_t route;
  rlpl_pkg::token_t tok_next;
  logic [IW-1:0]    idx_next;
  logic             active;
  logic             match;
  logic             better;
  logic             take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      route <= wr_route;
    end
  end

  always_comb begin
    active   = CW'(CELL_ID) < count;
    match    = ((route.dst ^ tok_in.addr) & route.mask) == '0;
    better   = !tok_in.have || (route.mask > tok_in.best.mask) ||
               ((route.mask == tok_in.best.mask) && (route.metric < tok_in.best.metric));
    take     = tok_in.live && active && match && better;
    tok_next = tok_in;
    idx_next = idx_in;
    if (take) begin
      tok_next.have = 1'b1;
      tok_next.best = route;
      idx_next      = IW'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_next.live;
    end
    tok_out.addr <= tok_next.addr;
    tok_out.have <= tok_next.have;
    tok_out.best <= tok_next.best;
    idx_out      <= idx_next;
  end

endmodule

### sv/route_longest_prefix_lookup_core.sv
// ----------------------------------------------------------------------------
// route_longest_prefix_lookup_core
// bounded ipv4 route table with longest-prefix lookup over a row of cells
// ----------------------------------------------------------------------------
// clear and insert answer from the output register; a lookup's token passes the
//   register of every cell in turn before the output register takes the result
// throughput: one word at a time; the token steps one route cell per cycle down the row
// clear and insert take a new word every cycle while the output register drains
// reset: synchronous; empties the table and drops any word in flight
// ----------------------------------------------------------------------------
module route_longest_prefix_lookup_core #(
  parameter int MAX_ROUTES = 64
) (
  input logic        clk,
  input logic        rst,
  rlpl_req_if.sink   req,
  rlpl_rsp_if.source rsp
);

  localparam int IW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CW = $clog2(MAX_ROUTES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                          state;
  logic [CW-1:0]                 count;
  logic                          ovalid;
  logic [rlpl_pkg::STATUS_W-1:0] ostatus;
  logic [rlpl_pkg::HIT_W-1:0]    oindex;
  rlpl_pkg::route_t              oroute;

  rlpl_pkg::token_t tok [MAX_ROUTES+1];
  logic [IW-1:0]    idx [MAX_ROUTES+1];
  rlpl_pkg::route_t wr_route;
  logic             accept;
  logic             full;
  logic             do_insert;
  logic             done;

  assign req.ready = (state == S_IDLE) && (!ovalid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = count >= CW'(MAX_ROUTES);
  assign do_insert = accept && (req.action == rlpl_pkg::ACT_INSERT) && !full;
  assign done      = tok[MAX_ROUTES].live;

  assign wr_route.dst     = req.route_dst;
  assign wr_route.mask    = req.route_mask;
  assign wr_route.gateway = req.route_gateway;
  assign wr_route.metric  = req.route_metric;
  assign wr_route.intf    = req.route_intf;

  assign tok[0].live = accept && (req.action == rlpl_pkg::ACT_LOOKUP);
  assign tok[0].addr = req.lookup_addr;
  assign tok[0].have = 1'b0;
  assign tok[0].best = '0;
  assign idx[0]      = '0;

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    rlpl_cell #(
      .CELL_ID(i),
      .IW     (IW),
      .CW     (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (do_insert && (count == CW'(i))),
      .wr_route(wr_route),
      .count   (count),
      .tok_in  (tok[i]),
      .idx_in  (idx[i]),
      .tok_out (tok[i+1]),
      .idx_out (idx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.action)
              rlpl_pkg::ACT_CLEAR:  count <= '0;
              rlpl_pkg::ACT_INSERT: begin
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              rlpl_pkg::ACT_LOOKUP: state <= S_SCAN;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (accept && (req.action != rlpl_pkg::ACT_LOOKUP)) begin
      ovalid <= 1'b1;
    end else if (done) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.action != rlpl_pkg::ACT_LOOKUP)) begin
      ostatus <= rlpl_pkg::STAT_OK;
      oindex  <= '0;
      oroute  <= '0;
      if (req.action == rlpl_pkg::ACT_INSERT) begin
        if (full) begin
          ostatus <= rlpl_pkg::STAT_FULL;
        end else begin
          oindex <= rlpl_pkg::HIT_W'(count);
        end
      end
    end else if (done) begin
      if (tok[MAX_ROUTES].have) begin
        ostatus <= rlpl_pkg::STAT_OK;
        oindex  <= rlpl_pkg::HIT_W'(idx[MAX_ROUTES]);
        oroute  <= tok[MAX_ROUTES].best;
      end else begin
        ostatus <= rlpl_pkg::STAT_MISS;
        oindex  <= '0;
        oroute  <= '0;
      end
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.status      = ostatus;
  assign rsp.hit_index   = oindex;
  assign rsp.hit_dst     = oroute.dst;
  assign rsp.hit_mask    = oroute.mask;
  assign rsp.hit_gateway = oroute.gateway;
  assign rsp.hit_metric  = oroute.metric;
  assign rsp.hit_intf    = oroute.intf;

endmodule

### sv/rlpl_checker.sv
// ----------------------------------------------------------------------------
// rlpl_checker
// port-level checks of the route lookup core
// ----------------------------------------------------------------------------
module rlpl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [rlpl_pkg::ACTION_W-1:0] req_action,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [rlpl_pkg::STATUS_W-1:0] rsp_status,
  input logic [rlpl_pkg::HIT_W-1:0]    rsp_hit_index,
  input logic [rlpl_pkg::ADDR_W-1:0]   rsp_hit_mask
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("stalled response changed");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == rlpl_pkg::ACT_LOOKUP) |=> !req_ready)
    else $error("new word taken during a lookup");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == rlpl_pkg::STAT_MISS || rsp_status == rlpl_pkg::STAT_FULL)
    |-> (rsp_hit_index == '0) && (rsp_hit_mask == '0))
    else $error("route fields set without a hit");

endmodule

bind route_longest_prefix_lookup_core rlpl_checker u_rlpl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_action   (req.action),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_hit_index(rsp.hit_index),
  .rsp_hit_mask (rsp.hit_mask)
);
